### sv/stmtg_pkg.sv
// Shared types and constants of the seven-point stencil triplet generator.
// Used by the channel interfaces, every module and the checker.
package stmtg_pkg;

   localparam int unsigned MAX_DIM_DEFAULT = 1024;

   localparam int SIZE_W      = 11;
   localparam int LAYER_W     = 2 * SIZE_W;
   localparam int NODE_W      = 31;
   localparam int ENTRY_W     = 33;
   localparam int COEF_W      = 64;
   localparam int DIR_W       = 3;
   localparam int NUM_DIRS    = 7;
   localparam int CSR_IDX_W   = 2;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [DIR_W-1:0] {
      DIR_DOWN_Z = 3'd0,
      DIR_DOWN_Y = 3'd1,
      DIR_WEST   = 3'd2,
      DIR_CENTRE = 3'd3,
      DIR_EAST   = 3'd4,
      DIR_UP_Y   = 3'd5,
      DIR_UP_Z   = 3'd6
   } dir_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SIZE_X = 2'd0,
      REG_SIZE_Y = 2'd1,
      REG_SIZE_Z = 2'd2
   } csr_reg_type;

   typedef logic [COEF_W-1:0] coef_type;

   // One classified node on its way from the front end to the back end.
   typedef struct packed {
      coef_type [NUM_DIRS-1:0] coef;
      logic [NODE_W-1:0]       node;
      logic [NUM_DIRS-1:0]     mask;
      logic                    grid_last;
   } node_entry_type;

   // Grid geometry and restart status from the front end.
   typedef struct packed {
      logic [SIZE_W-1:0]  size_x;
      logic [LAYER_W-1:0] layer;
      logic               restart;
   } geometry_type;

endpackage

### sv/stmtg_channels.sv
// Handshake channel interfaces: stencil node input, triplet output, register writes.
// Depends on stmtg_pkg.
interface stmtg_req_if;
   logic                      valid;
   logic                      ready;
   logic [stmtg_pkg::COEF_W-1:0] coef_down;
   logic [stmtg_pkg::COEF_W-1:0] coef_north;
   logic [stmtg_pkg::COEF_W-1:0] coef_west;
   logic [stmtg_pkg::COEF_W-1:0] coef_centre;
   logic [stmtg_pkg::COEF_W-1:0] coef_east;
   logic [stmtg_pkg::COEF_W-1:0] coef_south;
   logic [stmtg_pkg::COEF_W-1:0] coef_up;

   modport source (output valid, coef_down, coef_north, coef_west, coef_centre,
                   coef_east, coef_south, coef_up, input ready);
   modport sink (input valid, coef_down, coef_north, coef_west, coef_centre,
                 coef_east, coef_south, coef_up, output ready);
endinterface

interface stmtg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [stmtg_pkg::NODE_W-1:0]  row_index;
   logic [stmtg_pkg::NODE_W-1:0]  column_index;
   logic [stmtg_pkg::COEF_W-1:0]  coefficient;
   logic [stmtg_pkg::ENTRY_W-1:0] entry_number;
   logic [stmtg_pkg::DIR_W-1:0]   direction;
   logic                          last_of_node;
   logic                          last_of_grid;

   modport source (output valid, row_index, column_index, coefficient, entry_number,
                   direction, last_of_node, last_of_grid, input ready);
   modport sink (input valid, row_index, column_index, coefficient, entry_number,
                 direction, last_of_node, last_of_grid, output ready);
endinterface

interface stmtg_csr_if;
   logic                            valid;
   logic                            ready;
   logic [stmtg_pkg::CSR_IDX_W-1:0] index;
   logic [stmtg_pkg::SIZE_W-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

### sv/stmtg_front.sv
// Front end: size registers, grid traversal, and classification of each node.
// Depends on stmtg_pkg and stmtg_channels.
module stmtg_front #(
   parameter int unsigned MAX_DIM = stmtg_pkg::MAX_DIM_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   stmtg_req_if.sink                 req,
   stmtg_csr_if.sink                 csr,
   input  logic                      queue_full,
   output logic                      push,
   output stmtg_pkg::node_entry_type push_entry,
   output stmtg_pkg::geometry_type   geometry
);

   localparam int POS_W = $clog2(MAX_DIM);

   logic [stmtg_pkg::SIZE_W-1:0]  size_x_ff, size_x_in;
   logic [stmtg_pkg::SIZE_W-1:0]  size_y_ff, size_y_in;
   logic [stmtg_pkg::SIZE_W-1:0]  size_z_ff, size_z_in;
   logic [stmtg_pkg::LAYER_W-1:0] layer_ff, layer_in;
   logic                          settle_ff, settle_in;
   logic [POS_W-1:0]              pos_x_ff, pos_x_in;
   logic [POS_W-1:0]              pos_y_ff, pos_y_in;
   logic [POS_W-1:0]              pos_z_ff, pos_z_in;
   logic [stmtg_pkg::NODE_W-1:0]  node_ff, node_in;

   logic [stmtg_pkg::SIZE_W-1:0] eff_x, eff_y, eff_z;
   logic csr_fire, csr_hit, req_fire;
   logic last_x, last_y, last_z, grid_last;

   function automatic logic [stmtg_pkg::SIZE_W-1:0] eff_size(
      input logic [stmtg_pkg::SIZE_W-1:0] v);
      logic [stmtg_pkg::SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = stmtg_pkg::SIZE_W'(1);
      end else if (32'(v) > 32'(MAX_DIM)) begin
         r = stmtg_pkg::SIZE_W'(MAX_DIM);
      end
      return r;
   endfunction

   assign eff_x = eff_size(size_x_ff);
   assign eff_y = eff_size(size_y_ff);
   assign eff_z = eff_size(size_z_ff);

   assign csr.ready = 1'b1;
   assign csr_fire  = csr.valid && csr.ready;
   assign csr_hit   = csr_fire && (csr.index == stmtg_pkg::REG_SIZE_X ||
                                   csr.index == stmtg_pkg::REG_SIZE_Y ||
                                   csr.index == stmtg_pkg::REG_SIZE_Z);

   // Hold off input after reset or a write so layer_ff catches up.
   assign req.ready = !queue_full && !settle_ff;
   assign req_fire  = req.valid && req.ready;
   assign push      = req_fire;

   assign last_x    = (32'(pos_x_ff) + 32'd1) >= 32'(eff_x);
   assign last_y    = (32'(pos_y_ff) + 32'd1) >= 32'(eff_y);
   assign last_z    = (32'(pos_z_ff) + 32'd1) >= 32'(eff_z);
   assign grid_last = last_x && last_y && last_z;

   always_comb begin
      push_entry.coef[stmtg_pkg::DIR_DOWN_Z] = req.coef_down;
      push_entry.coef[stmtg_pkg::DIR_DOWN_Y] = req.coef_north;
      push_entry.coef[stmtg_pkg::DIR_WEST]   = req.coef_west;
      push_entry.coef[stmtg_pkg::DIR_CENTRE] = req.coef_centre;
      push_entry.coef[stmtg_pkg::DIR_EAST]   = req.coef_east;
      push_entry.coef[stmtg_pkg::DIR_UP_Y]   = req.coef_south;
      push_entry.coef[stmtg_pkg::DIR_UP_Z]   = req.coef_up;
      push_entry.node = node_ff;
      push_entry.mask[stmtg_pkg::DIR_DOWN_Z] = pos_z_ff != '0;
      push_entry.mask[stmtg_pkg::DIR_DOWN_Y] = pos_y_ff != '0;
      push_entry.mask[stmtg_pkg::DIR_WEST]   = pos_x_ff != '0;
      push_entry.mask[stmtg_pkg::DIR_CENTRE] = 1'b1;
      push_entry.mask[stmtg_pkg::DIR_EAST]   = !last_x;
      push_entry.mask[stmtg_pkg::DIR_UP_Y]   = !last_y;
      push_entry.mask[stmtg_pkg::DIR_UP_Z]   = !last_z;
      push_entry.grid_last = grid_last;
   end

   assign geometry.size_x  = eff_x;
   assign geometry.layer   = layer_ff;
   assign geometry.restart = csr_hit;

   always_comb begin
      size_x_in = size_x_ff;
      size_y_in = size_y_ff;
      size_z_in = size_z_ff;
      layer_in  = stmtg_pkg::LAYER_W'(eff_x) * stmtg_pkg::LAYER_W'(eff_y);
      settle_in = csr_fire;
      pos_x_in  = pos_x_ff;
      pos_y_in  = pos_y_ff;
      pos_z_in  = pos_z_ff;
      node_in   = node_ff;
      if (csr_fire) begin
         case (stmtg_pkg::csr_reg_type'(csr.index))
            stmtg_pkg::REG_SIZE_X: size_x_in = csr.data;
            stmtg_pkg::REG_SIZE_Y: size_y_in = csr.data;
            stmtg_pkg::REG_SIZE_Z: size_z_in = csr.data;
            default: ;
         endcase
      end
      if (csr_hit) begin
         pos_x_in = '0;
         pos_y_in = '0;
         pos_z_in = '0;
         node_in  = stmtg_pkg::NODE_W'(1);
      end else if (req_fire) begin
         if (grid_last) begin
            pos_x_in = '0;
            pos_y_in = '0;
            pos_z_in = '0;
            node_in  = stmtg_pkg::NODE_W'(1);
         end else begin
            node_in = node_ff + stmtg_pkg::NODE_W'(1);
            if (!last_x) begin
               pos_x_in = pos_x_ff + POS_W'(1);
            end else begin
               pos_x_in = '0;
               if (!last_y) begin
                  pos_y_in = pos_y_ff + POS_W'(1);
               end else begin
                  pos_y_in = '0;
                  pos_z_in = pos_z_ff + POS_W'(1);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      layer_ff <= layer_in;
      if (reset) begin
         size_x_ff <= stmtg_pkg::SIZE_W'(1);
         size_y_ff <= stmtg_pkg::SIZE_W'(1);
         size_z_ff <= stmtg_pkg::SIZE_W'(1);
         settle_ff <= 1'b1;
         pos_x_ff  <= '0;
         pos_y_ff  <= '0;
         pos_z_ff  <= '0;
         node_ff   <= stmtg_pkg::NODE_W'(1);
      end else begin
         size_x_ff <= size_x_in;
         size_y_ff <= size_y_in;
         size_z_ff <= size_z_in;
         settle_ff <= settle_in;
         pos_x_ff  <= pos_x_in;
         pos_y_ff  <= pos_y_in;
         pos_z_ff  <= pos_z_in;
         node_ff   <= node_in;
      end
   end

endmodule

### sv/stmtg_queue.sv
// Short FIFO of classified nodes between the front end and the back end.
// Depends on stmtg_pkg.
module stmtg_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  stmtg_pkg::node_entry_type push_entry,
   output logic                      full,
   input  logic                      pop,
   output logic                      head_valid,
   output stmtg_pkg::node_entry_type head
);

   localparam int DEPTH = stmtg_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   stmtg_pkg::node_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full       = count_ff == CNT_W'(DEPTH);
   assign head_valid = count_ff != '0;
   assign head       = slot_ff[rd_ptr_ff];

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      r = (32'(p) == DEPTH - 1) ? '0 : p + PTR_W'(1);
      return r;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

### sv/stmtg_back.sv
// Back end: walks the present directions of the head node, one triplet a cycle
// unless stalled, into the output register. Depends on stmtg_pkg and stmtg_channels.
module stmtg_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   input  stmtg_pkg::node_entry_type head,
   output logic                      pop,
   input  stmtg_pkg::geometry_type   geometry,
   stmtg_rsp_if.source               rsp
);

   logic                           busy_ff, busy_in;
   logic [stmtg_pkg::NUM_DIRS-1:0] rem_ff, rem_in;
   logic [stmtg_pkg::ENTRY_W-1:0]  entry_ff, entry_in;
   logic                           out_valid_ff, out_valid_in;
   logic [stmtg_pkg::NODE_W-1:0]   row_ff, col_ff;
   stmtg_pkg::coef_type            coef_ff;
   logic [stmtg_pkg::ENTRY_W-1:0]  num_ff;
   stmtg_pkg::dir_type             dir_ff;
   logic                           lnode_ff, lgrid_ff;

   logic [stmtg_pkg::NUM_DIRS-1:0] cur_mask, next_mask;
   stmtg_pkg::dir_type             sel;
   logic [stmtg_pkg::LAYER_W-1:0]  offset;
   logic [stmtg_pkg::NODE_W-1:0]   column;
   logic advance, fire, last_node;

   assign advance  = !out_valid_ff || rsp.ready;
   assign fire     = head_valid && advance;
   assign cur_mask = busy_ff ? rem_ff : head.mask;

   // Lowest present direction goes first.
   always_comb begin
      sel = stmtg_pkg::DIR_CENTRE;
      for (int i = stmtg_pkg::NUM_DIRS - 1; i >= 0; i--) begin
         if (cur_mask[i]) begin
            sel = stmtg_pkg::dir_type'(stmtg_pkg::DIR_W'(i));
         end
      end
      next_mask      = cur_mask;
      next_mask[sel] = 1'b0;
   end

   assign last_node = next_mask == '0;
   assign pop       = fire && last_node;

   always_comb begin
      unique case (sel)
         stmtg_pkg::DIR_DOWN_Z, stmtg_pkg::DIR_UP_Z: offset = geometry.layer;
         stmtg_pkg::DIR_DOWN_Y, stmtg_pkg::DIR_UP_Y:
            offset = stmtg_pkg::LAYER_W'(geometry.size_x);
         stmtg_pkg::DIR_WEST, stmtg_pkg::DIR_EAST: offset = stmtg_pkg::LAYER_W'(1);
         default: offset = '0;
      endcase
      if (sel < stmtg_pkg::DIR_CENTRE) begin
         column = head.node - stmtg_pkg::NODE_W'(offset);
      end else begin
         column = head.node + stmtg_pkg::NODE_W'(offset);
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      rem_in       = rem_ff;
      entry_in     = entry_ff;
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = head_valid;
      end
      if (fire) begin
         busy_in = !last_node;
         rem_in  = next_mask;
         // Wrap the entry count after the final triplet of the grid.
         entry_in = (last_node && head.grid_last) ? '0 : entry_ff + stmtg_pkg::ENTRY_W'(1);
      end
      if (geometry.restart) begin
         entry_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         row_ff   <= head.node;
         col_ff   <= column;
         coef_ff  <= head.coef[sel];
         num_ff   <= entry_ff;
         dir_ff   <= sel;
         lnode_ff <= last_node;
         lgrid_ff <= last_node && head.grid_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rem_ff       <= '0;
         entry_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rem_ff       <= rem_in;
         entry_ff     <= entry_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.row_index    = row_ff;
   assign rsp.column_index = col_ff;
   assign rsp.coefficient  = coef_ff;
   assign rsp.entry_number = num_ff;
   assign rsp.direction    = dir_ff;
   assign rsp.last_of_node = lnode_ff;
   assign rsp.last_of_grid = lgrid_ff;

endmodule

### sv/stencil_matrix_triplet_generator_core.sv
// Path: an accepted node is written into the node queue, and the back end then registers
// its triplets into the output register.
// Throughput: one triplet per cycle while the output is not stalled; a node yields one
// triplet per present direction (4 to 7 inside a large grid, 1 to 7 in general).
// A 2-entry node queue lets the input run ahead of the output by up to two nodes.
// Reset: sizes go to 1 and traversal to the first node; a settle register holds off
// input after reset and after any register write.
module stencil_matrix_triplet_generator_core #(
   parameter int unsigned MAX_DIM = stmtg_pkg::MAX_DIM_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   stmtg_req_if.sink   req_chan,
   stmtg_rsp_if.source rsp_chan,
   stmtg_csr_if.sink   csr_chan
);

   stmtg_pkg::node_entry_type push_entry, head;
   stmtg_pkg::geometry_type   geometry;
   logic push, queue_full, pop, head_valid;

   stmtg_front #(
      .MAX_DIM(MAX_DIM)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .csr        (csr_chan),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry),
      .geometry   (geometry)
   );

   stmtg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   stmtg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .geometry   (geometry),
      .rsp        (rsp_chan)
   );

endmodule

### sv/stmtg_checker.sv
// Port-level checks on the triplet output of the generator core, with its bind.
// Depends on stmtg_pkg.
module stmtg_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [stmtg_pkg::NODE_W-1:0] rsp_row_index,
   input logic [stmtg_pkg::NODE_W-1:0] rsp_column_index,
   input logic [stmtg_pkg::DIR_W-1:0]  rsp_direction,
   input logic                         rsp_last_of_node,
   input logic                         rsp_last_of_grid
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_grid_ends_node: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_grid |-> rsp_last_of_node)
      else $error("grid end without node end");

   a_grid_ends_on_centre: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_of_grid |-> rsp_direction == stmtg_pkg::DIR_CENTRE)
      else $error("grid end on a neighbour triplet");

   a_centre_diagonal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_direction == stmtg_pkg::DIR_CENTRE
      |-> rsp_column_index == rsp_row_index)
      else $error("centre triplet off the diagonal");

   a_up_z_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_direction == stmtg_pkg::DIR_UP_Z |-> rsp_last_of_node)
      else $error("up-z triplet not last of node");

endmodule

bind stencil_matrix_triplet_generator_core stmtg_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_row_index    (rsp_chan.row_index),
   .rsp_column_index (rsp_chan.column_index),
   .rsp_direction    (rsp_chan.direction),
   .rsp_last_of_node (rsp_chan.last_of_node),
   .rsp_last_of_grid (rsp_chan.last_of_grid)
);

### tb/tb_stencil_matrix_triplet_generator_core.sv
`timescale 1ns / 100ps
// Self-checking testbench of the seven-point stencil triplet generator core.
// Depends on stmtg_pkg, the channel interfaces and the core itself.
module tb_stencil_matrix_triplet_generator_core;

   localparam logic [stmtg_pkg::CSR_IDX_W-1:0] REG_SPARE = 2'd3;
   localparam int unsigned GRID_DIM_MAX = 1024;
   localparam int IDLE_MAX    = 11;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE_CYCLES = 8;

   typedef stmtg_pkg::coef_type coef_set_type [stmtg_pkg::NUM_DIRS];

   typedef struct packed {
      logic [stmtg_pkg::NODE_W-1:0]  row_index;
      logic [stmtg_pkg::NODE_W-1:0]  column_index;
      stmtg_pkg::coef_type           coefficient;
      logic [stmtg_pkg::ENTRY_W-1:0] entry_number;
      stmtg_pkg::dir_type            direction;
      logic                          last_of_node;
      logic                          last_of_grid;
   } triplet_type;

   logic clock = 1'b0;
   logic reset;

   stmtg_req_if req_bus ();
   stmtg_rsp_if rsp_bus ();
   stmtg_csr_if csr_bus ();

   stencil_matrix_triplet_generator_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always #5 clock = ~clock;

   // Predicted traversal state and grid registers
   logic [stmtg_pkg::SIZE_W-1:0]  grid_size [3];
   int unsigned                   cur_x, cur_y, cur_z;
   logic [stmtg_pkg::NODE_W-1:0]  node_num;
   logic [stmtg_pkg::ENTRY_W-1:0] entry_cnt;

   triplet_type pending_triplets [$];

   int  error_count = 0;
   int  cycle_count = 0;
   int  send_gap_max = 0;
   int  rsp_stall_max = 0;
   int  rsp_hold_cycles = 0;
   bit  node_offered = 1'b0;
   bit  csr_offered = 1'b0;

   function automatic longint unsigned effective_size(
      input logic [stmtg_pkg::SIZE_W-1:0] value);
      if (value == 0)
         return 1;
      if (value > GRID_DIM_MAX)
         return GRID_DIM_MAX;
      return value;
   endfunction

   function automatic void restart_traversal();
      cur_x = 0;
      cur_y = 0;
      cur_z = 0;
      node_num = stmtg_pkg::NODE_W'(1);
      entry_cnt = '0;
   endfunction

   function automatic void apply_reg_write(input logic [stmtg_pkg::CSR_IDX_W-1:0] idx,
                                           input logic [stmtg_pkg::SIZE_W-1:0] value);
      case (idx)
         stmtg_pkg::REG_SIZE_X: grid_size[stmtg_pkg::REG_SIZE_X] = value;
         stmtg_pkg::REG_SIZE_Y: grid_size[stmtg_pkg::REG_SIZE_Y] = value;
         stmtg_pkg::REG_SIZE_Z: grid_size[stmtg_pkg::REG_SIZE_Z] = value;
         default: return;
      endcase
      restart_traversal();
   endfunction

   // Expand one node into its triplets and queue them in emission order.
   function automatic void expand_node(input coef_set_type coefs);
      longint unsigned sx, sy, sz, layer, n;
      longint unsigned column [stmtg_pkg::NUM_DIRS];
      bit present [stmtg_pkg::NUM_DIRS];
      bit end_x, end_y, end_z;
      int count, k;
      triplet_type t;
      sx = effective_size(grid_size[stmtg_pkg::REG_SIZE_X]);
      sy = effective_size(grid_size[stmtg_pkg::REG_SIZE_Y]);
      sz = effective_size(grid_size[stmtg_pkg::REG_SIZE_Z]);
      layer = sx * sy;
      n = node_num;
      end_x = longint'(cur_x) + 1 >= sx;
      end_y = longint'(cur_y) + 1 >= sy;
      end_z = longint'(cur_z) + 1 >= sz;
      present = '{cur_z > 0, cur_y > 0, cur_x > 0, 1'b1, !end_x, !end_y, !end_z};
      column = '{n - layer, n - sx, n - 1, n, n + 1, n + sx, n + layer};
      count = 0;
      foreach (present[d])
         count += present[d];
      k = 0;
      for (int d = 0; d < stmtg_pkg::NUM_DIRS; d++) begin
         if (present[d]) begin
            t.row_index    = node_num;
            t.column_index = column[d][stmtg_pkg::NODE_W-1:0];
            t.coefficient  = coefs[d];
            t.entry_number = entry_cnt;
            t.direction    = stmtg_pkg::dir_type'(d);
            t.last_of_node = (k == count - 1);
            t.last_of_grid = (k == count - 1) && end_x && end_y && end_z;
            pending_triplets = {pending_triplets, t};
            entry_cnt = entry_cnt + stmtg_pkg::ENTRY_W'(1);
            k++;
         end
      end
      if (end_x && end_y && end_z) begin
         restart_traversal();
      end else begin
         node_num = node_num + stmtg_pkg::NODE_W'(1);
         if (!end_x) begin
            cur_x++;
         end else begin
            cur_x = 0;
            if (!end_y) begin
               cur_y++;
            end else begin
               cur_y = 0;
               cur_z++;
            end
         end
      end
   endfunction

   function automatic stmtg_pkg::coef_type random_coef();
      return {$urandom, $urandom};
   endfunction

   function automatic coef_set_type random_coefs();
      coef_set_type c;
      foreach (c[d])
         c[d] = random_coef();
      return c;
   endfunction

   function automatic logic [stmtg_pkg::SIZE_W-1:0] random_size();
      if ($urandom_range(0, 4) == 0)
         return stmtg_pkg::SIZE_W'($urandom_range(0, 2047));
      return stmtg_pkg::SIZE_W'($urandom_range(0, 4));
   endfunction

   function automatic void check_field(input string name, input logic [63:0] want,
                                       input logic [63:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   // Offer one node; hold it until the core takes it.
   task automatic send_node(input coef_set_type coefs);
      int gap;
      gap = $urandom_range(0, send_gap_max);
      if (gap > 0) begin
         if (node_offered)
            req_bus.valid <= 1'b0;
         node_offered = 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.coef_down   <= coefs[stmtg_pkg::DIR_DOWN_Z];
      req_bus.coef_north  <= coefs[stmtg_pkg::DIR_DOWN_Y];
      req_bus.coef_west   <= coefs[stmtg_pkg::DIR_WEST];
      req_bus.coef_centre <= coefs[stmtg_pkg::DIR_CENTRE];
      req_bus.coef_east   <= coefs[stmtg_pkg::DIR_EAST];
      req_bus.coef_south  <= coefs[stmtg_pkg::DIR_UP_Y];
      req_bus.coef_up     <= coefs[stmtg_pkg::DIR_UP_Z];
      node_offered = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expand_node(coefs);
   endtask

   task automatic send_random_nodes(input int count);
      repeat (count) send_node(random_coefs());
   endtask

   // Drop the input offer and hold until every predicted triplet has arrived.
   task automatic wait_for_drain();
      if (node_offered)
         req_bus.valid <= 1'b0;
      node_offered = 1'b0;
      while (pending_triplets.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [stmtg_pkg::CSR_IDX_W-1:0] idx,
                            input logic [stmtg_pkg::SIZE_W-1:0] value);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= value;
      csr_offered = 1'b1;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      apply_reg_write(idx, value);
   endtask

   task automatic finish_reg_writes();
      if (csr_offered)
         csr_bus.valid <= 1'b0;
      csr_offered = 1'b0;
   endtask

   task automatic set_grid(input int sx, input int sy, input int sz);
      wait_for_drain();
      write_reg(stmtg_pkg::REG_SIZE_X, stmtg_pkg::SIZE_W'(sx));
      write_reg(stmtg_pkg::REG_SIZE_Y, stmtg_pkg::SIZE_W'(sy));
      write_reg(stmtg_pkg::REG_SIZE_Z, stmtg_pkg::SIZE_W'(sz));
      finish_reg_writes();
   endtask

   // Reset sizes give a one-node grid: centre only, both last flags, wrap every node.
   task automatic test_single_node_grid();
      coef_set_type c;
      send_gap_max = 0;
      rsp_stall_max = 0;
      foreach (c[d])
         c[d] = '0;
      send_node(c);
      foreach (c[d])
         c[d] = '1;
      send_node(c);
      send_random_nodes(1);
   endtask

   // 2x2x2 touches every face from both sides; one extra node checks the wrap.
   task automatic test_small_grid_faces();
      send_gap_max = IDLE_MAX;
      rsp_stall_max = IDLE_MAX;
      set_grid(2, 2, 2);
      send_random_nodes(9);
   endtask

   // One node wide in x: no west or east neighbour anywhere.
   task automatic test_one_wide_x();
      set_grid(1, 2, 2);
      send_random_nodes(4);
   endtask

   task automatic test_size_extremes();
      set_grid(0, 2047, 2047);
      send_random_nodes(2);
      set_grid(2047, 0, 1024);
      send_random_nodes(2);
      // a write to the unused index must not restart the traversal
      wait_for_drain();
      write_reg(REG_SPARE, '1);
      finish_reg_writes();
      send_random_nodes(2);
   endtask

   task automatic test_output_backpressure();
      send_gap_max = 0;
      rsp_stall_max = 0;
      set_grid(4, 3, 2);
      rsp_hold_cycles = 120;
      send_random_nodes(14);
      wait_for_drain();
      send_gap_max = IDLE_MAX;
      rsp_stall_max = IDLE_MAX;
      send_random_nodes(6);
   endtask

   task automatic test_random_grids();
      stmtg_pkg::csr_reg_type size_regs [3];
      int sent, batch;
      size_regs = '{stmtg_pkg::REG_SIZE_X, stmtg_pkg::REG_SIZE_Y, stmtg_pkg::REG_SIZE_Z};
      sent = 0;
      while (sent < 50) begin
         wait_for_drain();
         foreach (size_regs[r])
            if ($urandom_range(0, 2) != 0)
               write_reg(size_regs[r], random_size());
         finish_reg_writes();
         send_gap_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
         rsp_stall_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
         batch = $urandom_range(6, 20);
         send_random_nodes(batch);
         sent += batch;
      end
   endtask

   initial begin
      reset               <= 1'b1;
      req_bus.valid       <= 1'b0;
      req_bus.coef_down   <= '0;
      req_bus.coef_north  <= '0;
      req_bus.coef_west   <= '0;
      req_bus.coef_centre <= '0;
      req_bus.coef_east   <= '0;
      req_bus.coef_south  <= '0;
      req_bus.coef_up     <= '0;
      csr_bus.valid       <= 1'b0;
      csr_bus.index       <= stmtg_pkg::REG_SIZE_X;
      csr_bus.data        <= '0;
      grid_size = '{1, 1, 1};
      restart_traversal();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_single_node_grid();
      test_small_grid_faces();
      test_one_wide_x();
      test_size_extremes();
      test_output_backpressure();
      test_random_grids();

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_triplets.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   // Result receiver: random stall per beat, plus a long hold-off on request.
   initial begin : rsp_ready_driver
      int gap, hold;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset === 1'b1);
      forever begin
         if (rsp_hold_cycles > 0) begin
            hold = rsp_hold_cycles;
            rsp_hold_cycles = 0;
            rsp_bus.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         gap = $urandom_range(0, rsp_stall_max);
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
      end
   end

   always @(posedge clock) begin : triplet_check
      triplet_type want;
      if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (pending_triplets.size() == 0) begin
            $error("unexpected triplet beat: row %0d column %0d", rsp_bus.row_index,
                   rsp_bus.column_index);
            error_count++;
         end else begin
            want = pending_triplets.pop_front();
            check_field("row_index", want.row_index, rsp_bus.row_index);
            check_field("column_index", want.column_index, rsp_bus.column_index);
            check_field("coefficient", want.coefficient, rsp_bus.coefficient);
            check_field("entry_number", want.entry_number, rsp_bus.entry_number);
            check_field("direction", want.direction, rsp_bus.direction);
            check_field("last_of_node", want.last_of_node, rsp_bus.last_of_node);
            check_field("last_of_grid", want.last_of_grid, rsp_bus.last_of_grid);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule
